>>> hdl/max_pool_2d_stream_assert.svh
// assertion macros for the max pooling block
// used by max_pool_2d_stream.sv; expects clk and arst_n in scope
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// property that holds in the same cycle
`define MP2D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define MP2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/mp2d_pkg.sv
// shared types and constants of the 2x2 max pooling stream
// no dependencies
package mp2d_pkg;

	localparam int MAP_SIZE    = 28;
	localparam int KERNEL      = 2;
	localparam int STRIDE      = 2;
	localparam int SAMPLE_W    = 16;
	localparam int STORE_DEPTH = KERNEL * MAP_SIZE;
	localparam int POS_W       = $clog2(MAP_SIZE);
	localparam int KW          = (KERNEL > 1) ? $clog2(KERNEL) : 1;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// start of the last window that fits along one axis
	localparam int LAST_START = (KERNEL <= MAP_SIZE) ?
		((MAP_SIZE - KERNEL) / STRIDE) * STRIDE : 0;
	localparam int LAST_END   = LAST_START + KERNEL - 1;

	typedef logic signed [SAMPLE_W-1:0] q88_t;

	// one bit per position: a whole window ends there
	function automatic logic [MAP_SIZE-1:0] end_mask_f();
		logic [MAP_SIZE-1:0] msk;
		int s;
		msk = '0;
		for (int p = 0; p < MAP_SIZE; p++) begin
			s = p + 1 - KERNEL;
			if (KERNEL <= MAP_SIZE && s >= 0 && (s % STRIDE) == 0 && s <= LAST_START)
				msk[p] = 1'b1;
		end
		return msk;
	endfunction

	localparam logic [MAP_SIZE-1:0] END_MASK = end_mask_f();

endpackage

>>> hdl/mp2d_stream_if.sv
// valid/ready channels of the max pooling block
// depends on mp2d_pkg
interface mp2d_sample_if import mp2d_pkg::*; ();
	logic valid;
	logic ready;
	q88_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface mp2d_pool_if import mp2d_pkg::*; ();
	logic valid;
	logic ready;
	q88_t max_value;
	logic last_of_map;

	modport source (output valid, output max_value, output last_of_map, input ready);
	modport sink (input valid, input max_value, input last_of_map, output ready);
endinterface

>>> hdl/max_pool_2d_stream.sv
// channel   dir  payload                  request moves
// samples   in   sample (Q8.8)            one map sample, row-major
// pooled    out  max_value, last_of_map   one window maximum
//
// a sample that ends no window only writes the line store
// a sample that ends a window starts a scan through read, drain and hold states:
// the line store has one read port, so the window is read one entry a cycle
// the result sits in an output register; a new sample is taken while it waits
// a stalled output holds the block only when the next window result is ready
// reset clears counters and control; the line store is not cleared
//
// depends on mp2d_pkg, mp2d_stream_if.sv, max_pool_2d_stream_assert.svh
`include "max_pool_2d_stream_assert.svh"

module max_pool_2d_stream import mp2d_pkg::*; (
	input logic clk,
	input logic arst_n,
	mp2d_sample_if.sink samples,
	mp2d_pool_if.source pooled
);

	localparam int SUM_W = ADDR_W + 1;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_HOLD  = 4'b1000
	} state_t;

	state_t state_q;

	logic [POS_W-1:0] row_q, col_q, left_q;
	logic [KW-1:0]    slot_q, rd_slot_q, l_q, m_q;
	logic             last_q;

	q88_t             store [STORE_DEPTH];
	q88_t             rd_data_s1;
	logic             rd_vld_s1, first_s1;
	q88_t             best_q;

	logic             out_vld_q, out_last_q;
	q88_t             out_val_q;

	logic             in_acc, win_end, rd_en, rd_done, out_free;
	logic [SUM_W-1:0] wr_sum, rd_sum;
	logic [KW-1:0]    top_slot;

	// handshake and window detection
	assign samples.ready = (state_q == S_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign win_end       = END_MASK[row_q] && END_MASK[col_q];
	assign rd_en         = (state_q == S_READ);
	assign rd_done       = (l_q == KW'(KERNEL - 1)) && (m_q == KW'(KERNEL - 1));
	assign out_free      = !out_vld_q || pooled.ready;
	assign top_slot      = (slot_q == KW'(KERNEL - 1)) ? '0 : slot_q + 1'b1;

	// line store addresses
	assign wr_sum = SUM_W'(slot_q) * SUM_W'(MAP_SIZE) + SUM_W'(col_q);
	assign rd_sum = SUM_W'(rd_slot_q) * SUM_W'(MAP_SIZE) + SUM_W'(left_q) + SUM_W'(m_q);

	// line store: write on request, read during window scan
	always_ff @(posedge clk) begin
		if (in_acc)
			store[wr_sum[ADDR_W-1:0]] <= samples.sample;
		if (rd_en)
			rd_data_s1 <= store[rd_sum[ADDR_W-1:0]];
	end

	// position counters and ring slot of the current row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (in_acc) begin
			if (col_q == POS_W'(MAP_SIZE - 1)) begin
				col_q <= '0;
				if (row_q == POS_W'(MAP_SIZE - 1)) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					slot_q <= top_slot;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// sequencer; the scan runs only after the write, so no forwarding is needed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			l_q       <= '0;
			m_q       <= '0;
			rd_slot_q <= '0;
			rd_vld_s1 <= 1'b0;
			first_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			first_s1  <= rd_en && (l_q == '0) && (m_q == '0);
			case (state_q)
				S_IDLE: begin
					if (in_acc && win_end) begin
						state_q   <= S_READ;
						l_q       <= '0;
						m_q       <= '0;
						rd_slot_q <= top_slot;
					end
				end
				S_READ: begin
					if (rd_done) begin
						state_q <= S_DRAIN;
					end else if (m_q == KW'(KERNEL - 1)) begin
						m_q       <= '0;
						l_q       <= l_q + 1'b1;
						rd_slot_q <= (rd_slot_q == KW'(KERNEL - 1)) ? '0 : rd_slot_q + 1'b1;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// window origin and end-of-map mark, taken with the request
	always_ff @(posedge clk) begin
		if (in_acc && win_end) begin
			left_q <= col_q - POS_W'(KERNEL - 1);
			last_q <= (row_q == POS_W'(LAST_END)) && (col_q == POS_W'(LAST_END));
		end
	end

	// running signed maximum over the read data
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (first_s1 || rd_data_s1 > best_q))
			best_q <= rd_data_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_HOLD && out_free) begin
			out_vld_q <= 1'b1;
		end else if (pooled.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && out_free) begin
			out_val_q  <= best_q;
			out_last_q <= last_q;
		end
	end

	assign pooled.valid       = out_vld_q;
	assign pooled.max_value   = out_val_q;
	assign pooled.last_of_map = out_last_q;

	// checks
	`MP2D_ASSERT_NEXT(a_scan_starts, in_acc && win_end, state_q == S_READ,
		"window end did not start a scan")
	`MP2D_ASSERT(a_read_from_scan, !rd_vld_s1 || $past(state_q == S_READ),
		"read data without a scan cycle")
	`MP2D_ASSERT(a_load_from_hold, !$rose(out_vld_q) || $past(state_q == S_HOLD),
		"result loaded outside hold")
	`MP2D_ASSERT(a_slot_range, slot_q <= KW'(KERNEL - 1) && rd_slot_q <= KW'(KERNEL - 1),
		"ring slot out of range")

endmodule

>>> tb/tb_top.sv
// self-checking testbench of the 2x2 max pooling stream, with a built-in pooling predictor
// depends on mp2d_pkg, mp2d_stream_if.sv and max_pool_2d_stream.sv
`timescale 1ns / 1ps

module tb_top import mp2d_pkg::*; ();

	localparam int LINE_DEPTH   = KERNEL * MAP_SIZE;
	localparam int FINAL_START  = (KERNEL <= MAP_SIZE) ?
		((MAP_SIZE - KERNEL) / STRIDE) * STRIDE : 0;
	localparam int RANDOM_ITEMS = 926;
	localparam int DRAIN_AT     = 480;
	localparam int TAIL_ITEMS   = 100;
	localparam int SETTLE_CYC   = 32;
	localparam int STALL_LIMIT  = 1000;

	typedef struct {
		q88_t value;
		bit   drain_first;
	} feed_item_t;

	typedef struct {
		q88_t max_value;
		logic last_of_map;
	} pool_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// tb-side drivers of the channel inputs, known from time zero
	logic src_valid = 1'b0;
	q88_t src_sample = '0;
	logic snk_ready = 1'b0;

	feed_item_t   sample_feed [$];
	pool_result_t pool_want [$];

	// predictor state: line store and position counters
	q88_t line_buf [LINE_DEPTH];
	int   cur_row = 0;
	int   cur_col = 0;

	int taken_cnt = 0;
	int err_cnt = 0;
	int src_gap = 0;
	int snk_gap = 0;
	int src_gap_pct = 20;
	int snk_stall_pct = 20;
	int quiet_cnt = 0;

	mp2d_sample_if samples_ch ();
	mp2d_pool_if   pooled_ch ();

	assign samples_ch.valid  = src_valid;
	assign samples_ch.sample = src_sample;
	assign pooled_ch.ready   = snk_ready;

	max_pool_2d_stream DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_ch),
		.pooled (pooled_ch)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// reset held from time zero, released once
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// true if a whole window ends at position p along one axis
	function automatic bit closes_window(int p);
		int s;
		s = p + 1 - KERNEL;
		return (KERNEL <= MAP_SIZE) && (s >= 0) && (s % STRIDE == 0) && (s <= FINAL_START);
	endfunction

	// store one sample, queue the window maximum it completes, advance position
	function automatic void pool_predict(q88_t v);
		pool_result_t res;
		int top;
		int left;
		q88_t best;
		q88_t s;
		line_buf[(cur_row % KERNEL) * MAP_SIZE + cur_col] = v;
		if (closes_window(cur_row) && closes_window(cur_col)) begin
			top = cur_row + 1 - KERNEL;
			left = cur_col + 1 - KERNEL;
			best = line_buf[(top % KERNEL) * MAP_SIZE + left];
			for (int l = 0; l < KERNEL; l++) begin
				for (int m = 0; m < KERNEL; m++) begin
					s = line_buf[((top + l) % KERNEL) * MAP_SIZE + left + m];
					if (s > best)
						best = s;
				end
			end
			res.max_value = best;
			res.last_of_map = (top == FINAL_START && left == FINAL_START);
			pool_want.push_back(res);
		end
		cur_col++;
		if (cur_col >= MAP_SIZE) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= MAP_SIZE)
				cur_row = 0;
		end
	endfunction

	// idle chance in percent for the next stretch
	function automatic int pick_rate();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 20;
			default: return 50;
		endcase
	endfunction

	// random sample biased toward extremes and near-equal values
	function automatic q88_t rand_sample();
		case ($urandom_range(0, 9))
			0: return q88_t'(16'h7FFF);
			1: return q88_t'(16'h8000);
			2: return q88_t'($urandom_range(0, 4)) - q88_t'(2);
			3: return q88_t'(16'h7FF0 | $urandom_range(0, 15));
			4: return q88_t'(16'h8000 | $urandom_range(0, 15));
			default: return q88_t'($urandom());
		endcase
	endfunction

	// sample driver: fed from sample_feed, predicts on each accepted request
	always @(posedge clk or negedge arst_n) begin : drive_samples
		feed_item_t item;
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_sample <= '0;
			src_gap = 0;
		end else begin
			if (src_valid && samples_ch.ready) begin
				pool_predict(src_sample);
				taken_cnt++;
				if (taken_cnt % 50 == 0)
					src_gap_pct = pick_rate();
			end
			if (!src_valid || samples_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					src_valid <= 1'b0;
				end else if (sample_feed.size() == 0) begin
					src_valid <= 1'b0;
				end else if (sample_feed[0].drain_first && pool_want.size() != 0) begin
					// hold off until every pooled result is back
					src_valid <= 1'b0;
				end else if (sample_feed.size() > TAIL_ITEMS &&
						$urandom_range(0, 99) < src_gap_pct) begin
					src_gap = $urandom_range(0, 17);
					src_valid <= 1'b0;
				end else begin
					item = sample_feed.pop_front();
					src_sample <= item.value;
					src_valid <= 1'b1;
				end
			end
		end
	end

	// pooled monitor: random stalls, compares against the oldest expected result
	always @(posedge clk or negedge arst_n) begin : check_pooled
		pool_result_t want;
		if (!arst_n) begin
			snk_ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (pooled_ch.valid && snk_ready) begin
				if (pool_want.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: pooled result with none expected: max %0d last %0b",
							$realtime, pooled_ch.max_value, pooled_ch.last_of_map);
				end else begin
					want = pool_want.pop_front();
					if (pooled_ch.max_value !== want.max_value ||
							pooled_ch.last_of_map !== want.last_of_map) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display({"%0t: pooled mismatch: max exp %0d got %0d, ",
								"last exp %0b got %0b"},
								$realtime, want.max_value, pooled_ch.max_value,
								want.last_of_map, pooled_ch.last_of_map);
					end
				end
				quiet_cnt++;
				if (quiet_cnt % 40 == 0)
					snk_stall_pct = pick_rate();
			end
			if (snk_gap > 0) begin
				snk_gap--;
				snk_ready <= 1'b0;
			end else if (sample_feed.size() > TAIL_ITEMS &&
					$urandom_range(0, 99) < snk_stall_pct) begin
				snk_gap = $urandom_range(0, 17);
				snk_ready <= 1'b0;
			end else begin
				snk_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request moving on either channel
	always @(posedge clk) begin : watchdog
		int idle_cyc;
		if (!arst_n || (src_valid && samples_ch.ready) || (pooled_ch.valid && snk_ready)) begin
			idle_cyc = 0;
		end else begin
			idle_cyc++;
			if (idle_cyc >= STALL_LIMIT) begin
				$display("max_pool_2d_stream verification failed");
				$finish;
			end
		end
	end

	// stimulus: directed extremes in the first row, then random maps
	initial begin : stimulus
		feed_item_t item;
		q88_t edge_vals [24];
		edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8001,
			16'h7FFE, 16'h5555, 16'hAAAA, 16'h0100, 16'hFF00, 16'h8000,
			16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000,
			16'hFFFF, 16'hFFFE, 16'h00FF, 16'hFF01, 16'h4000, 16'hC000};
		foreach (edge_vals[i]) begin
			item.value = edge_vals[i];
			item.drain_first = 1'b0;
			sample_feed.push_back(item);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			item.value = rand_sample();
			item.drain_first = (n == DRAIN_AT);
			sample_feed.push_back(item);
		end

		// wait for all requests to go in and every result to come out
		@(posedge arst_n);
		while (sample_feed.size() != 0 || src_valid || pool_want.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		if (err_cnt == 0 && pool_want.size() == 0) begin
			$display("max_pool_2d_stream verification clean");
		end else begin
			$display("max_pool_2d_stream verification failed");
		end
		$finish;
	end

endmodule
